// ===== src/ultrasonic_echo_ranger_core_defines.svh =====
// Assertion macros for the echo ranger core.
// Expects clk and rst_n in the scope of each use.
`ifndef ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define UER_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define UER_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/uer_pkg.sv =====
// Shared types and constants of the echo ranger core.
// No dependencies.
`default_nettype none

package uer_pkg;

    localparam int TRIG_W     = 16;
    localparam int TIME_W     = 24;
    localparam int SCALE_W    = 16;
    localparam int RAW_W      = 24;
    localparam int DIST_W     = 27;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int COUNTER_BITS_DEFAULT = 24;

    localparam int DIST_SHIFT_IN  = 5;
    localparam int DIST_SHIFT_OUT = 8;

    localparam logic [TRIG_W-1:0]  TRIGGER_TICKS_RST = 16'd80;
    localparam logic [TIME_W-1:0]  HOLDOFF_TICKS_RST = 24'd12000;
    localparam logic [TIME_W-1:0]  TIMEOUT_TICKS_RST = 24'd296000;
    localparam logic [SCALE_W-1:0] SOUND_SCALE_RST   = 16'd2228;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRIGGER_TICKS = 2'd0,
        CFG_HOLDOFF_TICKS = 2'd1,
        CFG_TIMEOUT_TICKS = 2'd2,
        CFG_SOUND_SCALE   = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TRIG   = 2'd1,
        PH_HOLD   = 2'd2,
        PH_LISTEN = 2'd3
    } phase_t;

endpackage

`default_nettype wire

// ===== src/uer_tick_if.sv =====
// Input channel of the echo ranger core: one timer tick per transfer.
// Depends on nothing.
`default_nettype none

interface uer_tick_if;
    logic valid;
    logic ready;
    logic kind;
    logic echo_level;

    modport source (output valid, output kind, output echo_level, input ready);
    modport sink   (input valid, input kind, input echo_level, output ready);
endinterface

`default_nettype wire

// ===== src/uer_result_if.sv =====
// Result channel of the echo ranger core: one result per tick.
// Widths from uer_pkg.
`default_nettype none

interface uer_result_if;
    logic                       valid;
    logic                       ready;
    logic                       trigger_drive;
    logic                       busy_res;
    logic                       done_res;
    logic                       timed_out;
    logic [uer_pkg::RAW_W-1:0]  raw_ticks;
    logic [uer_pkg::DIST_W-1:0] distance_q8;

    modport source (output valid, output trigger_drive, output busy_res, output done_res,
                    output timed_out, output raw_ticks, output distance_q8, input ready);
    modport sink   (input valid, input trigger_drive, input busy_res, input done_res,
                    input timed_out, input raw_ticks, input distance_q8, output ready);
endinterface

`default_nettype wire

// ===== src/ultrasonic_echo_ranger_core.sv =====
// Echo ranger core: result valid is registered and rises in the cycle after a tick transfer.
// Throughput one tick per cycle; a tick is taken while the result register
// is empty or its result leaves in the same cycle.
// The distance multiply (19 x 16 bits) sits between the count register and
// the result register. Reset clears phase, counter, echo history and result
// valid, and loads the register reset values.
`default_nettype none
`include "ultrasonic_echo_ranger_core_defines.svh"

module ultrasonic_echo_ranger_core #(
    parameter int COUNTER_BITS = uer_pkg::COUNTER_BITS_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    uer_tick_if.sink                              tick,
    uer_result_if.source                          result,
    input  wire logic                             cfg_wr_en,
    input  wire logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CMP_W  = (COUNTER_BITS > uer_pkg::RAW_W) ? COUNTER_BITS : uer_pkg::RAW_W;
    localparam int SHR_W  = uer_pkg::RAW_W - uer_pkg::DIST_SHIFT_IN;
    localparam int PROD_W = SHR_W + uer_pkg::SCALE_W;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX     = {COUNTER_BITS{1'b1}};
    localparam logic [CMP_W-1:0]        CNT_MAX_EXT = CMP_W'(CNT_MAX);

    function automatic logic [CMP_W-1:0] clamp_lim(input logic [CMP_W-1:0] v);
        return (v > CNT_MAX_EXT) ? CNT_MAX_EXT : v;
    endfunction

    logic [uer_pkg::TRIG_W-1:0]  trigger_ticks_reg;
    logic [uer_pkg::TIME_W-1:0]  holdoff_ticks_reg;
    logic [uer_pkg::TIME_W-1:0]  timeout_ticks_reg;
    logic [uer_pkg::SCALE_W-1:0] sound_scale_reg;

    uer_pkg::phase_t             phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]     phase_count_reg, phase_count_next;
    logic                        prev_echo_reg;

    logic                        result_valid_reg;
    logic                        trigger_drive_reg, trigger_drive_next;
    logic                        busy_res_reg, busy_res_next;
    logic                        done_res_reg, done_res_next;
    logic                        timed_out_reg, timed_out_next;
    logic [uer_pkg::RAW_W-1:0]   raw_ticks_reg, raw_ticks_next;
    logic [uer_pkg::DIST_W-1:0]  distance_q8_reg, distance_q8_next;

    logic                        tick_fire;
    uer_pkg::phase_t             eff_phase;
    logic [COUNTER_BITS-1:0]     eff_count;
    logic [COUNTER_BITS-1:0]     bumped;
    logic [CMP_W-1:0]            bumped_ext;
    logic [CMP_W-1:0]            trig_lim, hold_lim, tmo_lim;
    logic                        trig_end, hold_end, echo_fall, listen_tmo;
    logic [CMP_W-1:0]            count_ext;
    logic [uer_pkg::RAW_W-1:0]   raw_now;
    logic [PROD_W-1:0]           product;

    assign tick.ready = !result_valid_reg || result.ready;
    assign tick_fire  = tick.valid && tick.ready;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_ticks_reg <= uer_pkg::TRIGGER_TICKS_RST;
            holdoff_ticks_reg <= uer_pkg::HOLDOFF_TICKS_RST;
            timeout_ticks_reg <= uer_pkg::TIMEOUT_TICKS_RST;
            sound_scale_reg   <= uer_pkg::SOUND_SCALE_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                uer_pkg::CFG_TRIGGER_TICKS: trigger_ticks_reg <= cfg_data[uer_pkg::TRIG_W-1:0];
                uer_pkg::CFG_HOLDOFF_TICKS: holdoff_ticks_reg <= cfg_data[uer_pkg::TIME_W-1:0];
                uer_pkg::CFG_TIMEOUT_TICKS: timeout_ticks_reg <= cfg_data[uer_pkg::TIME_W-1:0];
                uer_pkg::CFG_SOUND_SCALE:   sound_scale_reg   <= cfg_data[uer_pkg::SCALE_W-1:0];
                default:                    sound_scale_reg   <= sound_scale_reg;
            endcase
        end
    end

    // Phase decode and end conditions
    always_comb
    begin
        eff_phase = phase_reg;
        eff_count = phase_count_reg;
        if (phase_reg == uer_pkg::PH_IDLE && tick.kind)
        begin
            eff_phase = uer_pkg::PH_TRIG;
            eff_count = '0;
        end
        bumped     = (eff_count == CNT_MAX) ? eff_count : eff_count + 1'b1;
        bumped_ext = CMP_W'(bumped);

        trig_lim = clamp_lim(CMP_W'((trigger_ticks_reg == '0) ? uer_pkg::TRIG_W'(1)
                                                              : trigger_ticks_reg));
        hold_lim = clamp_lim(CMP_W'(holdoff_ticks_reg));
        tmo_lim  = clamp_lim(CMP_W'((timeout_ticks_reg == '0) ? uer_pkg::TIME_W'(1)
                                                              : timeout_ticks_reg));

        trig_end   = bumped_ext >= trig_lim;
        hold_end   = bumped_ext >= hold_lim;
        echo_fall  = prev_echo_reg && !tick.echo_level;
        listen_tmo = !echo_fall && (bumped_ext >= tmo_lim);
    end

    // Next state
    always_comb
    begin
        phase_next       = eff_phase;
        phase_count_next = eff_count;
        unique case (eff_phase)
            uer_pkg::PH_IDLE:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
            uer_pkg::PH_TRIG:
            begin
                phase_count_next = bumped;
                if (trig_end)
                begin
                    phase_count_next = '0;
                    phase_next = (holdoff_ticks_reg == '0) ? uer_pkg::PH_LISTEN
                                                           : uer_pkg::PH_HOLD;
                end
            end
            uer_pkg::PH_HOLD:
            begin
                phase_count_next = bumped;
                if (hold_end)
                begin
                    phase_count_next = '0;
                    phase_next       = uer_pkg::PH_LISTEN;
                end
            end
            uer_pkg::PH_LISTEN:
            begin
                phase_count_next = bumped;
                if (echo_fall || listen_tmo)
                begin
                    phase_count_next = '0;
                    phase_next       = uer_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase
    end

    // Distance from the held count
    assign count_ext = CMP_W'(phase_count_reg);
    assign raw_now   = count_ext[uer_pkg::RAW_W-1:0];
    assign product   = PROD_W'(raw_now[uer_pkg::RAW_W-1:uer_pkg::DIST_SHIFT_IN])
                     * PROD_W'(sound_scale_reg);

    // Result fields
    always_comb
    begin
        trigger_drive_next = (eff_phase == uer_pkg::PH_TRIG);
        busy_res_next      = (phase_next != uer_pkg::PH_IDLE);
        done_res_next      = 1'b0;
        timed_out_next     = 1'b0;
        raw_ticks_next     = '0;
        distance_q8_next   = '0;
        if (eff_phase == uer_pkg::PH_LISTEN)
        begin
            if (echo_fall)
            begin
                done_res_next    = 1'b1;
                raw_ticks_next   = raw_now;
                distance_q8_next = product[uer_pkg::DIST_SHIFT_OUT +: uer_pkg::DIST_W];
            end
            else if (listen_tmo)
            begin
                done_res_next  = 1'b1;
                timed_out_next = 1'b1;
            end
        end
    end

    // Measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= uer_pkg::PH_IDLE;
            phase_count_reg <= '0;
            prev_echo_reg   <= 1'b0;
        end
        else if (tick_fire)
        begin
            phase_reg       <= phase_next;
            phase_count_reg <= phase_count_next;
            prev_echo_reg   <= tick.echo_level;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            trigger_drive_reg <= trigger_drive_next;
            busy_res_reg      <= busy_res_next;
            done_res_reg      <= done_res_next;
            timed_out_reg     <= timed_out_next;
            raw_ticks_reg     <= raw_ticks_next;
            distance_q8_reg   <= distance_q8_next;
        end
    end

    assign result.valid         = result_valid_reg;
    assign result.trigger_drive = trigger_drive_reg;
    assign result.busy_res      = busy_res_reg;
    assign result.done_res      = done_res_reg;
    assign result.timed_out     = timed_out_reg;
    assign result.raw_ticks     = raw_ticks_reg;
    assign result.distance_q8   = distance_q8_reg;

    `UER_ASSERT_NOW(a_idle_count_zero, phase_reg == uer_pkg::PH_IDLE, phase_count_reg == '0, "count not cleared in idle")
    `UER_ASSERT_NOW(a_trig_busy, result_valid_reg && trigger_drive_reg, busy_res_reg, "trigger without busy")
    `UER_ASSERT_NOW(a_done_not_busy, result_valid_reg && done_res_reg, !busy_res_reg, "done while busy")
    `UER_ASSERT_NOW(a_tmo_zero, result_valid_reg && timed_out_reg, done_res_reg && raw_ticks_reg == '0 && distance_q8_reg == '0, "timeout result not zero")
    `UER_ASSERT_NEXT(a_idle_stays, tick_fire && phase_reg == uer_pkg::PH_IDLE && !tick.kind, phase_reg == uer_pkg::PH_IDLE, "left idle without start")

endmodule

`default_nettype wire
